### design/rf3_pkg.sv
package rf3_pkg;

  localparam int PIX_W = 8;
  localparam int COL_W = 10;
  localparam int ROW_W = 12;
  localparam int FW_W  = 11;
  localparam int FH_W  = 13;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam int MAX_WIDTH = 1024;

  localparam logic [FW_W-1:0] WIDTH_MIN  = 11'd3;
  localparam logic [FW_W-1:0] WIDTH_MAX  = 11'd1024;
  localparam logic [FH_W-1:0] HEIGHT_MIN = 13'd3;
  localparam logic [FH_W-1:0] HEIGHT_MAX = 13'd4096;

  localparam logic [FW_W-1:0]   WIDTH_RESET  = 11'd1024;
  localparam logic [FH_W-1:0]   HEIGHT_RESET = 13'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_RANK_MODE    = 2'd2
  } cfg_index_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_MIN    = 2'd0,
    MODE_MEDIAN = 2'd1,
    MODE_MAX    = 2'd2
  } rank_mode_t;

  typedef logic [PIX_W-1:0] pix_t;

  // One window column, kept sorted.
  typedef struct packed {
    pix_t hi;
    pix_t mid;
    pix_t lo;
  } col_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_t sort3(input pix_t a, input pix_t b, input pix_t c);
    col_t s;
    s.lo  = min3(a, b, c);
    s.mid = med3(a, b, c);
    s.hi  = max3(a, b, c);
    return s;
  endfunction

  // Rank of nine values from three sorted columns.
  function automatic pix_t rank_pick(input col_t a, input col_t b, input col_t c,
                                     input logic [MODE_W-1:0] mode);
    pix_t r;
    case (mode)
      MODE_MIN:    r = min3(a.lo, b.lo, c.lo);
      MODE_MEDIAN: r = med3(max3(a.lo, b.lo, c.lo), med3(a.mid, b.mid, c.mid),
                            min3(a.hi, b.hi, c.hi));
      default:     r = max3(a.hi, b.hi, c.hi);
    endcase
    return r;
  endfunction

endpackage

### design/rf3_line_store.sv
module rf3_line_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/rf3_col_cell.sv
module rf3_col_cell (
  input  logic          clk,
  input  logic          shift,
  input  rf3_pkg::col_t col_in,
  output rf3_pkg::col_t col_q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      col_q <= col_in;
    end
  end

endmodule

### design/rank_filter_3x3_top.sv
// Streaming 3x3 rank filter: takes one 8-bit pixel per clock in raster order and returns,
// for every interior position, the minimum, median or maximum of its 3x3 neighborhood
// (rank_mode), plus every border pixel unchanged, each tagged with row and column. A
// filtered result is registered through the line store read, the column shift into the cell
// chain and the rank register after the pixel that completes its window. A pixel that yields
// both a filtered and a border result holds the output register for both results, so the input
// stalls on those pixels (last column, last row); every other pixel flows at one per clock
// while result_stall is low. The two line stores are single-port-read, single-port-write
// RAMs indexed by column; a read and the write of the previous pixel never hit the same
// column. Stores are not cleared at reset. Write frame_width, frame_height and rank_mode
// only while the block is idle.
module rank_filter_3x3_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pixel_valid,
  output logic                               pixel_stall,
  input  logic [rf3_pkg::PIX_W-1:0]          pixel_in,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [rf3_pkg::PIX_W-1:0]          out_value,
  output logic [rf3_pkg::ROW_W-1:0]          out_row,
  output logic [rf3_pkg::COL_W-1:0]          out_col,
  output logic                               out_is_border,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rf3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rf3_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // configuration
  logic [rf3_pkg::FW_W-1:0]   frame_width;
  logic [rf3_pkg::FH_W-1:0]   frame_height;
  logic [rf3_pkg::MODE_W-1:0] rank_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rf3_pkg::WIDTH_RESET;
      frame_height <= rf3_pkg::HEIGHT_RESET;
      rank_mode    <= rf3_pkg::MODE_MEDIAN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rf3_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[rf3_pkg::FW_W-1:0];
        rf3_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[rf3_pkg::FH_W-1:0];
        rf3_pkg::CFG_RANK_MODE:    rank_mode    <= cfg_data[rf3_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [rf3_pkg::FW_W-1:0] w_eff;
  logic [rf3_pkg::FH_W-1:0] h_eff;

  always_comb begin
    if (frame_width < rf3_pkg::WIDTH_MIN) begin
      w_eff = rf3_pkg::WIDTH_MIN;
    end else if (frame_width > rf3_pkg::WIDTH_MAX) begin
      w_eff = rf3_pkg::WIDTH_MAX;
    end else begin
      w_eff = frame_width;
    end
    if (frame_height < rf3_pkg::HEIGHT_MIN) begin
      h_eff = rf3_pkg::HEIGHT_MIN;
    end else if (frame_height > rf3_pkg::HEIGHT_MAX) begin
      h_eff = rf3_pkg::HEIGHT_MAX;
    end else begin
      h_eff = frame_height;
    end
  end

  // pipeline control
  logic en;
  logic accept;
  logic s1_valid;
  logic s2_valid;
  logic s3_filt_pend;
  logic s3_border_pend;

  assign en          = !(s3_filt_pend || s3_border_pend) ||
                       (!result_stall && (s3_filt_pend ^ s3_border_pend));
  assign pixel_stall = !en;
  assign accept      = pixel_valid && en;

  // position of the arriving pixel
  logic [rf3_pkg::COL_W-1:0] col_count;
  logic [rf3_pkg::ROW_W-1:0] row_count;
  logic [rf3_pkg::COL_W-1:0] col_pos;
  logic [rf3_pkg::ROW_W-1:0] row_pos;
  logic [rf3_pkg::COL_W-1:0] col_count_next;
  logic [rf3_pkg::ROW_W-1:0] row_count_next;
  logic                      pos_filt;
  logic                      pos_border;

  logic                      col_wrap;
  logic [rf3_pkg::FH_W-1:0]  row_inc;
  logic [rf3_pkg::FW_W-1:0]  col_plus;
  logic [rf3_pkg::FH_W-1:0]  row_plus;

  always_comb begin
    // a column beyond a shrunk frame starts the next row
    col_wrap = {1'b0, col_count} >= w_eff;
    col_pos  = col_wrap ? '0 : col_count;
    row_inc  = {1'b0, row_count} + {{(rf3_pkg::FH_W-1){1'b0}}, col_wrap};
    row_pos  = (row_inc >= h_eff) ? '0 : row_inc[rf3_pkg::ROW_W-1:0];

    col_plus = {1'b0, col_pos} + 11'd1;
    row_plus = {1'b0, row_pos} + 13'd1;
    if (col_plus >= w_eff) begin
      col_count_next = '0;
      row_count_next = (row_plus >= h_eff) ? '0 : row_plus[rf3_pkg::ROW_W-1:0];
    end else begin
      col_count_next = col_plus[rf3_pkg::COL_W-1:0];
      row_count_next = row_pos;
    end

    pos_filt   = (row_pos >= 12'd2) && (col_pos >= 10'd2);
    pos_border = (row_pos == '0) || ({1'b0, row_pos} == h_eff - 13'd1) ||
                 (col_pos == '0) || ({1'b0, col_pos} == w_eff - 11'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // stage 1: line store read in flight
  rf3_pkg::pix_t             s1_pix;
  logic [rf3_pkg::COL_W-1:0] s1_col;
  logic [rf3_pkg::ROW_W-1:0] s1_row;
  logic                      s1_filt;
  logic                      s1_border;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix    <= pixel_in;
      s1_col    <= col_pos;
      s1_row    <= row_pos;
      s1_filt   <= pos_filt;
      s1_border <= pos_border;
    end
  end

  rf3_pkg::pix_t upper_q;
  rf3_pkg::pix_t middle_q;
  logic          commit;

  assign commit = en && s1_valid;

  rf3_line_store #(
    .DEPTH (rf3_pkg::MAX_WIDTH),
    .WIDTH (rf3_pkg::PIX_W)
  ) u_store_upper (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_pos),
    .rd_data (upper_q),
    .wr_en   (commit),
    .wr_addr (s1_col),
    .wr_data (middle_q)
  );

  rf3_line_store #(
    .DEPTH (rf3_pkg::MAX_WIDTH),
    .WIDTH (rf3_pkg::PIX_W)
  ) u_store_middle (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_pos),
    .rd_data (middle_q),
    .wr_en   (commit),
    .wr_addr (s1_col),
    .wr_data (s1_pix)
  );

  // window: three column cells, newest column enters sorted
  rf3_pkg::col_t col_new;
  rf3_pkg::col_t win_col [3];

  assign col_new = rf3_pkg::sort3(upper_q, middle_q, s1_pix);

  rf3_col_cell u_cell_new (
    .clk    (clk),
    .shift  (commit),
    .col_in (col_new),
    .col_q  (win_col[2])
  );

  rf3_col_cell u_cell_mid (
    .clk    (clk),
    .shift  (commit),
    .col_in (win_col[2]),
    .col_q  (win_col[1])
  );

  rf3_col_cell u_cell_old (
    .clk    (clk),
    .shift  (commit),
    .col_in (win_col[1]),
    .col_q  (win_col[0])
  );

  // stage 2: window holds this pixel's neighborhood
  rf3_pkg::pix_t             s2_pix;
  logic [rf3_pkg::COL_W-1:0] s2_col;
  logic [rf3_pkg::ROW_W-1:0] s2_row;
  logic                      s2_filt;
  logic                      s2_border;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      s2_pix    <= s1_pix;
      s2_col    <= s1_col;
      s2_row    <= s1_row;
      s2_filt   <= s1_filt;
      s2_border <= s1_border;
    end
  end

  // stage 3: output register, filtered result leaves before the border one
  rf3_pkg::pix_t             s3_rank;
  rf3_pkg::pix_t             s3_pix;
  logic [rf3_pkg::COL_W-1:0] s3_col;
  logic [rf3_pkg::ROW_W-1:0] s3_row;
  logic                      out_take;

  assign out_take = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_filt_pend   <= 1'b0;
      s3_border_pend <= 1'b0;
    end else if (en) begin
      s3_filt_pend   <= s2_valid && s2_filt;
      s3_border_pend <= s2_valid && s2_border;
    end else if (out_take) begin
      s3_filt_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid) begin
      s3_rank <= rf3_pkg::rank_pick(win_col[0], win_col[1], win_col[2], rank_mode);
      s3_pix  <= s2_pix;
      s3_col  <= s2_col;
      s3_row  <= s2_row;
    end
  end

  assign result_valid  = s3_filt_pend || s3_border_pend;
  assign out_value     = s3_filt_pend ? s3_rank : s3_pix;
  assign out_row       = s3_filt_pend ? s3_row - 12'd1 : s3_row;
  assign out_col       = s3_filt_pend ? s3_col - 10'd1 : s3_col;
  assign out_is_border = !s3_filt_pend;
  assign out_last      = !(s3_filt_pend && s3_border_pend);

`ifndef ASSERT_OFF
  a_no_store_collision: assert property (@(posedge clk) disable iff (rst)
    accept && s1_valid |-> col_pos != s1_col)
    else $error("line store read and write hit the same column");

  a_filt_interior: assert property (@(posedge clk) disable iff (rst)
    s3_filt_pend |-> (s3_row >= 12'd2) && (s3_col >= 10'd2))
    else $error("filtered result at a border position");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    s3_filt_pend && s3_border_pend && out_take |=> !s3_filt_pend && s3_border_pend)
    else $error("border result lost after filtered result");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted pixel did not enter the pipeline");
`endif

endmodule
